// ===== rtl/core/aoi_pkg.sv =====
// Shared types, constants and microcode program of the admittance offset integrator.
`default_nettype none

package aoi_pkg;

	// Time step ceiling, 0.05 s in Q0.24 rounded
	localparam int unsigned DtMax   = 838861;
	localparam int unsigned DtW     = 20;
	localparam int unsigned OneQ16  = 65536;
	localparam int unsigned UcDepth = 11;
	localparam int unsigned UpcW    = $clog2(UcDepth);

	typedef struct packed {
		logic               req_type;
		logic signed [31:0] force_sample;
		logic [23:0]        time_step;
	} req_t;

	typedef struct packed {
		logic signed [31:0] offset_out;
		logic signed [31:0] velocity_out;
		logic signed [31:0] filtered_out;
	} rsp_t;

	// Configuration register map
	typedef enum logic [2:0] {
		CFG_TARGET   = 3'd0,
		CFG_IMASS    = 3'd1,
		CFG_DAMP     = 3'd2,
		CFG_STIFF    = 3'd3,
		CFG_OLIM     = 3'd4,
		CFG_VLIM     = 3'd5,
		CFG_WEIGHT   = 3'd6,
		CFG_FLOOR_EN = 3'd7
	} cfg_reg_t;

	localparam int unsigned CfgIdxW = 3;

	// Request kinds
	localparam logic REQ_UPDATE = 1'b0;
	localparam logic REQ_RESET  = 1'b1;

	// Multiplier operand A: unsigned gains and step
	typedef enum logic [2:0] {
		MA_ZERO   = 3'd0,
		MA_DAMP   = 3'd1,
		MA_WEIGHT = 3'd2,
		MA_STIFF  = 3'd3,
		MA_DT     = 3'd4,
		MA_IMASS  = 3'd5
	} mul_a_t;

	// Multiplier operand B: signed state and intermediates
	typedef enum logic [2:0] {
		MB_ZERO = 3'd0,
		MB_VEL  = 3'd1,
		MB_DIFF = 3'd2,
		MB_OFF  = 3'd3,
		MB_NET  = 3'd4,
		MB_IMP  = 3'd5,
		MB_VNEW = 3'd6
	} mul_b_t;

	// Datapath action, consumes the product issued in the previous step
	typedef enum logic [3:0] {
		ACT_NONE  = 4'd0,
		ACT_DIFF  = 4'd1,
		ACT_NET_D = 4'd2,
		ACT_FILT  = 4'd3,
		ACT_NET_K = 4'd4,
		ACT_IMP   = 4'd5,
		ACT_DV    = 4'd6,
		ACT_DX    = 4'd7,
		ACT_RST   = 4'd8
	} act_t;

	typedef struct packed {
		mul_a_t a_sel;
		mul_b_t b_sel;
		act_t   act;
		logic   jump_rst;  // branch to the reset routine on a reset item
		logic   last;      // final step, commits the result
	} ucode_t;

	localparam logic [UpcW-1:0] UpcRst = UpcW'(10);

	function automatic ucode_t ucode_rom(input logic [UpcW-1:0] upc);
		ucode_t uc;
		uc = '{a_sel: MA_ZERO, b_sel: MB_ZERO, act: ACT_NONE, jump_rst: 1'b0, last: 1'b0};
		unique case (upc)
			UpcW'(0):  uc = '{MA_DAMP,   MB_VEL,  ACT_DIFF,  1'b1, 1'b0};
			UpcW'(1):  uc = '{MA_WEIGHT, MB_DIFF, ACT_NET_D, 1'b0, 1'b0};
			UpcW'(2):  uc = '{MA_STIFF,  MB_OFF,  ACT_FILT,  1'b0, 1'b0};
			UpcW'(3):  uc = '{MA_ZERO,   MB_ZERO, ACT_NET_K, 1'b0, 1'b0};
			UpcW'(4):  uc = '{MA_DT,     MB_NET,  ACT_NONE,  1'b0, 1'b0};
			UpcW'(5):  uc = '{MA_ZERO,   MB_ZERO, ACT_IMP,   1'b0, 1'b0};
			UpcW'(6):  uc = '{MA_IMASS,  MB_IMP,  ACT_NONE,  1'b0, 1'b0};
			UpcW'(7):  uc = '{MA_ZERO,   MB_ZERO, ACT_DV,    1'b0, 1'b0};
			UpcW'(8):  uc = '{MA_DT,     MB_VNEW, ACT_NONE,  1'b0, 1'b0};
			UpcW'(9):  uc = '{MA_ZERO,   MB_ZERO, ACT_DX,    1'b0, 1'b1};
			UpcW'(10): uc = '{MA_ZERO,   MB_ZERO, ACT_RST,   1'b0, 1'b1};
			default:   uc = '{MA_ZERO,   MB_ZERO, ACT_NONE,  1'b0, 1'b1};
		endcase
		return uc;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/admittance_offset_integrator_unit.sv =====
// Top level of the single-axis admittance offset integrator.
//
// Usage:
//  - req channel (req_valid/req_stall/req): one beat is an update step or a
//    reset item. A beat is taken when req_valid is high and req_stall low.
//  - rsp channel (rsp_valid/rsp_stall/rsp): exactly one result beat per
//    request beat: offset, velocity and filtered force after the item.
//  - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//    cfg_ready is always high; write only while the block is idle.
//  - An update beat runs every microcode step; a reset item branches from
//    the first step to the reset step. A new request is taken the cycle
//    after the result is registered, so one item is in work at a time.
//    Work runs on the single shared 33x33 multiplier along the microcode
//    chain filter -> net force -> impulse -> velocity -> offset.
//  - Result sits in an output register; while it waits under rsp_stall the
//    block still takes and works on the next request, holding only at its
//    final microstep until the output register frees up.
//  - arst_n clears state, config to its defaults, the busy flag and the result valid flag.
`default_nettype none

module admittance_offset_integrator_unit (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               req_valid,
	output logic                              req_stall,
	input  aoi_pkg::req_t                     req,
	output logic                              rsp_valid,
	input  wire                               rsp_stall,
	output aoi_pkg::rsp_t                     rsp,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [aoi_pkg::CfgIdxW-1:0]       cfg_index,
	input  wire  [31:0]                       cfg_data
);

	localparam int unsigned DtW  = aoi_pkg::DtW;
	localparam int unsigned UpcW = aoi_pkg::UpcW;

	// Rounding offsets: every shift rounds half up
	localparam logic signed [65:0] Half24 = 66'sd8388608;
	localparam logic signed [65:0] Half20 = 66'sd524288;
	localparam logic signed [65:0] Half16 = 66'sd32768;
	localparam logic signed [65:0] Half12 = 66'sd2048;
	localparam logic signed [43:0] NetMax = 44'sd2147483647;
	localparam logic signed [43:0] NetMin = -44'sd2147483648;

	// ---------------- configuration registers ----------------
	logic signed [31:0] target_q;
	logic [31:0]        imass_q;
	logic [31:0]        damp_q;
	logic [31:0]        stiff_q;
	logic [30:0]        olim_q;
	logic [30:0]        vlim_q;
	logic [16:0]        weight_q;
	logic               floor_en_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= '0;
			imass_q    <= 32'(aoi_pkg::OneQ16);
			damp_q     <= '0;
			stiff_q    <= '0;
			olim_q     <= '0;
			vlim_q     <= '0;
			weight_q   <= 17'd16384;
			floor_en_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (aoi_pkg::cfg_reg_t'(cfg_index))
				aoi_pkg::CFG_TARGET:   target_q   <= $signed(cfg_data);
				aoi_pkg::CFG_IMASS:    imass_q    <= cfg_data;
				aoi_pkg::CFG_DAMP:     damp_q     <= cfg_data;
				aoi_pkg::CFG_STIFF:    stiff_q    <= cfg_data;
				aoi_pkg::CFG_OLIM:     olim_q     <= cfg_data[30:0];
				aoi_pkg::CFG_VLIM:     vlim_q     <= cfg_data[30:0];
				aoi_pkg::CFG_WEIGHT:   weight_q   <= cfg_data[16:0];
				aoi_pkg::CFG_FLOOR_EN: floor_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Weight above one acts as one
	logic [16:0] weight_eff;
	assign weight_eff = (weight_q > 17'(aoi_pkg::OneQ16)) ? 17'(aoi_pkg::OneQ16) : weight_q;

	logic signed [31:0] target_eff;
	assign target_eff = (floor_en_q && target_q[31]) ? 32'sd0 : target_q;

	// ---------------- sequencer ----------------
	logic            busy_q;
	logic [UpcW-1:0] upc_q;
	aoi_pkg::ucode_t uc;
	logic            out_free;
	logic            adv;
	logic            req_acc;

	assign uc        = aoi_pkg::ucode_rom(upc_q);
	assign out_free  = !rsp_valid || !rsp_stall;
	// final step waits for the output register
	assign adv       = busy_q && (!uc.last || out_free);
	assign req_stall = busy_q;
	assign req_acc   = req_valid && !req_stall;

	// item registers
	logic signed [31:0] force_q;
	logic [DtW-1:0]     dt_q;
	logic               rst_item_q;

	logic signed [31:0] force_in;
	logic [DtW-1:0]     dt_in;
	assign force_in = (floor_en_q && req.force_sample[31]) ? 32'sd0 : req.force_sample;
	assign dt_in    = (req.time_step > 24'(aoi_pkg::DtMax)) ?
	                  DtW'(aoi_pkg::DtMax) : req.time_step[DtW-1:0];

	always_ff @(posedge clk) begin
		if (req_acc) begin
			force_q    <= force_in;
			dt_q       <= dt_in;
			rst_item_q <= (req.req_type == aoi_pkg::REQ_RESET);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			upc_q  <= '0;
		end else if (req_acc) begin
			busy_q <= 1'b1;
			upc_q  <= '0;
		end else if (adv) begin
			if (uc.last) begin
				busy_q <= 1'b0;
			end else if (uc.jump_rst && rst_item_q) begin
				upc_q <= aoi_pkg::UpcRst;
			end else begin
				upc_q <= upc_q + UpcW'(1);
			end
		end
	end

	// ---------------- datapath ----------------
	logic signed [31:0] filt_q;
	logic signed [31:0] off_q;
	logic signed [31:0] vel_q;
	logic               primed_q;
	logic signed [32:0] diff_q;
	logic signed [43:0] net_acc_q;
	logic signed [31:0] net_q;
	logic signed [31:0] imp_q;
	logic signed [31:0] vnew_q;
	logic signed [65:0] prod_q;

	// shared multiplier, operands picked by the control word
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;

	always_comb begin
		unique case (uc.a_sel)
			aoi_pkg::MA_ZERO:   mul_a = '0;
			aoi_pkg::MA_DAMP:   mul_a = $signed({1'b0, damp_q});
			aoi_pkg::MA_WEIGHT: mul_a = $signed(33'(weight_eff));
			aoi_pkg::MA_STIFF:  mul_a = $signed({1'b0, stiff_q});
			aoi_pkg::MA_DT:     mul_a = $signed(33'(dt_q));
			aoi_pkg::MA_IMASS:  mul_a = $signed({1'b0, imass_q});
			default:            mul_a = '0;
		endcase
		unique case (uc.b_sel)
			aoi_pkg::MB_ZERO: mul_b = '0;
			aoi_pkg::MB_VEL:  mul_b = 33'(vel_q);
			aoi_pkg::MB_DIFF: mul_b = diff_q;
			aoi_pkg::MB_OFF:  mul_b = 33'(off_q);
			aoi_pkg::MB_NET:  mul_b = 33'(net_q);
			aoi_pkg::MB_IMP:  mul_b = 33'(imp_q);
			aoi_pkg::MB_VNEW: mul_b = 33'(vnew_q);
			default:          mul_b = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_q <= mul_a * mul_b;
		end
	end

	// rounded shifts of the previous product
	logic signed [65:0] p24, p20, p16, p12;
	logic signed [41:0] rnd24;
	logic signed [45:0] rnd20;
	logic signed [49:0] rnd16;
	logic signed [53:0] rnd12;
	assign p24   = prod_q + Half24;
	assign p20   = prod_q + Half20;
	assign p16   = prod_q + Half16;
	assign p12   = prod_q + Half12;
	assign rnd24 = p24[65:24];
	assign rnd20 = p20[65:20];
	assign rnd16 = p16[65:16];
	assign rnd12 = p12[65:12];

	// net force saturation
	logic signed [43:0] net_sum;
	logic signed [31:0] net_sat;
	assign net_sum = net_acc_q + 44'(filt_q) - 44'(rnd24);
	always_comb begin
		priority if (net_sum > NetMax) net_sat = 32'sh7FFFFFFF;
		else if (net_sum < NetMin)     net_sat = 32'sh80000000;
		else                           net_sat = net_sum[31:0];
	end

	// velocity update and clamp
	logic signed [54:0] v_sum;
	logic signed [54:0] vlim_p;
	logic signed [54:0] v_cl;
	assign v_sum  = 55'(vel_q) + 55'(rnd12);
	assign vlim_p = $signed(55'(vlim_q));
	always_comb begin
		priority if (v_sum > vlim_p) v_cl = vlim_p;
		else if (v_sum < -vlim_p)    v_cl = -vlim_p;
		else                         v_cl = v_sum;
	end

	// offset update, clamp, boundary stop and zero-step freeze
	logic signed [42:0] x_sum;
	logic signed [42:0] olim_p;
	logic signed [42:0] x_cl;
	logic               at_limit;
	logic signed [31:0] x_fin;
	logic signed [31:0] v_fin;
	assign x_sum  = 43'(off_q) + 43'(rnd24);
	assign olim_p = $signed(43'(olim_q));
	always_comb begin
		priority if (x_sum > olim_p) x_cl = olim_p;
		else if (x_sum < -olim_p)    x_cl = -olim_p;
		else                         x_cl = x_sum;
	end
	assign at_limit = ((x_cl >= olim_p) && (vnew_q > 32'sd0)) ||
	                  ((x_cl <= -olim_p) && (vnew_q < 32'sd0));
	assign v_fin    = at_limit ? 32'sd0 : vnew_q;
	assign x_fin    = (dt_q == '0) ? off_q : x_cl[31:0];

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (adv) begin
			unique case (uc.act)
				aoi_pkg::ACT_DIFF:  diff_q    <= 33'(force_q) - 33'(filt_q);
				aoi_pkg::ACT_NET_D: net_acc_q <= -44'(target_eff) - 44'(rnd24);
				aoi_pkg::ACT_NET_K: net_q     <= net_sat;
				aoi_pkg::ACT_IMP:   imp_q     <= rnd20[31:0];
				aoi_pkg::ACT_DV:    vnew_q    <= v_cl[31:0];
				default: ;
			endcase
		end
	end

	// architectural state and output register
	logic          rsp_valid_q;
	aoi_pkg::rsp_t rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q   <= '0;
			off_q    <= '0;
			vel_q    <= '0;
			primed_q <= 1'b0;
		end else if (adv) begin
			unique case (uc.act)
				aoi_pkg::ACT_FILT: begin
					// filt + w*(F - filt), first sample loads directly
					filt_q   <= primed_q ? (filt_q + rnd16[31:0]) : force_q;
					primed_q <= 1'b1;
				end
				aoi_pkg::ACT_DX: begin
					off_q <= x_fin;
					vel_q <= v_fin;
				end
				aoi_pkg::ACT_RST: begin
					filt_q   <= force_q;
					off_q    <= '0;
					vel_q    <= '0;
					primed_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv && uc.act == aoi_pkg::ACT_DX) begin
			rsp_q.offset_out   <= x_fin;
			rsp_q.velocity_out <= v_fin;
			rsp_q.filtered_out <= filt_q;
		end else if (adv && uc.act == aoi_pkg::ACT_RST) begin
			rsp_q.offset_out   <= '0;
			rsp_q.velocity_out <= '0;
			rsp_q.filtered_out <= force_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv && uc.last) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/core/aoi_checker.sv =====
// Port-level checks for the admittance offset integrator, bound to the top level.
`default_nettype none

module aoi_checker (
	input wire           clk,
	input wire           arst_n,
	input wire           req_valid,
	input wire           req_stall,
	input wire           rsp_valid,
	input wire           rsp_stall,
	input aoi_pkg::rsp_t rsp
);

	// stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result beat dropped or changed under stall");

	// taking a request makes the block busy
	a_busy_after_acc: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("no busy after request beat");

	// busy only follows a request beat
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(req_stall) |-> $past(req_valid))
		else $error("busy without request beat");

	// a new result only comes out of a running computation
	a_rsp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result beat without work in flight");

endmodule

bind admittance_offset_integrator_unit aoi_checker u_aoi_checker (.*);

`default_nettype wire

// ===== tb/admittance_offset_integrator_unit_tb.sv =====
// Self-checking testbench of the admittance offset integrator: predicts each result beat.
`timescale 1ns / 1ps

module admittance_offset_integrator_unit_tb;
	import aoi_pkg::*;

	localparam int     ClkHalf    = 10;      // 20 ns period
	localparam int     CycleLimit = 400000;  // watchdog, ends the run as a failure
	localparam int     DrainWait  = 14;      // covers the update latency, plus margin
	localparam longint StepCeil   = longint'(DtMax);
	localparam longint WeightOne  = longint'(OneQ16);
	localparam longint NetMax     = (longint'(1) << 31) - 1;
	localparam longint NetMin     = -(longint'(1) << 31);

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	req_t                 req;
	logic                 rsp_valid;
	logic                 rsp_stall;
	rsp_t                 rsp;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CfgIdxW-1:0]   cfg_index;
	logic [31:0]          cfg_data;

	admittance_offset_integrator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#ClkHalf;
		clk = 1'b1;
		#ClkHalf;
	end

	// ------------------------------------------------------------------
	// Predictor state: register copies and the controller state,
	// all held as 64-bit signed so no intermediate product can wrap.
	// ------------------------------------------------------------------
	longint tgt_force  = 0;
	longint inv_mass   = 65536;
	longint damp_gain  = 0;
	longint stiff_gain = 0;
	longint off_lim    = 0;
	longint vel_lim    = 0;
	longint smooth_w   = 16384;
	bit     floor_en   = 1'b1;

	longint flt_force     = 0;
	longint off_val       = 0;
	longint vel_val       = 0;
	bit     filter_primed = 1'b0;

	rsp_t        expected_motion[$];  // one entry per accepted request beat, oldest first
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	bit          idle_en        = 1'b1;  // random gaps on both channels
	int unsigned hold_left      = 0;     // long receiver hold-off, consumed by the stall process
	int unsigned burst_left     = 0;

	// Round to nearest, ties toward +inf: add half, then floor-shift.
	function automatic longint round_shr(longint x, int unsigned n);
		return (x + (longint'(1) << (n - 1))) >>> n;
	endfunction

	function automatic longint floor_neg(longint f);
		return (floor_en && f < 0) ? 0 : f;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// One controller step (filter, net force, impulse, velocity, offset) or a reset item.
	function automatic rsp_t integrate_step(req_t r);
		longint f, w, dt, tgt, net, imp, dv, v, x, prev_x;
		rsp_t   o;
		f = floor_neg(longint'(r.force_sample));
		if (r.req_type == REQ_RESET) begin
			// reset item loads the filter and parks the motion, step ignored
			flt_force     = f;
			off_val       = 0;
			vel_val       = 0;
			filter_primed = 1'b1;
		end else begin
			w   = (smooth_w > WeightOne) ? WeightOne : smooth_w;
			dt  = longint'(r.time_step);
			tgt = floor_neg(tgt_force);
			if (!filter_primed) begin
				flt_force     = f;
				filter_primed = 1'b1;
			end else begin
				flt_force = round_shr(w * f + (WeightOne - w) * flt_force, 16);
			end
			if (dt > StepCeil)
				dt = StepCeil;
			net = flt_force - tgt - round_shr(damp_gain * vel_val, 24)
				- round_shr(stiff_gain * off_val, 24);
			net = clip(net, NetMin, NetMax);
			imp = round_shr(net * dt, 20);
			dv  = round_shr(imp * inv_mass, 12);
			v   = clip(vel_val + dv, -vel_lim, vel_lim);
			prev_x = off_val;
			x   = clip(off_val + round_shr(dt * v, 24), -off_lim, off_lim);
			// pinned at the boundary while still pushing outward
			if ((x >= off_lim && v > 0) || (x <= -off_lim && v < 0))
				v = 0;
			if (dt == 0)
				x = prev_x;
			off_val = x;
			vel_val = v;
		end
		o.offset_out   = off_val[31:0];
		o.velocity_out = vel_val[31:0];
		o.filtered_out = flt_force[31:0];
		return o;
	endfunction

	function automatic req_t make_req(logic kind, logic [31:0] f, logic [23:0] dt);
		req_t r;
		r.req_type     = kind;
		r.force_sample = f;
		r.time_step    = dt;
		return r;
	endfunction

	task automatic log_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("[%0t] %s: got %h, want %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------
	// Request side: drive at negedge, accept at posedge, predict on accept.
	// ------------------------------------------------------------------
	task automatic send_beat(req_t item);
		@(negedge clk);
		req       = item;
		req_valid = 1'b1;
		do @(posedge clk); while (req_stall);
		expected_motion.push_back(integrate_step(item));
		// random idle gap after about one beat in four, when idling is on
		if (idle_en && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			req_valid = 1'b0;
			repeat ($urandom_range(0, 15)) @(negedge clk);
		end
	endtask

	// Block is idle once every expected result has come back and the pipe has drained.
	task automatic settle();
		@(negedge clk);
		req_valid = 1'b0;
		while (expected_motion.size() != 0)
			@(posedge clk);
		repeat (DrainWait) @(posedge clk);
	endtask

	task automatic write_register(cfg_reg_t idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_TARGET:   tgt_force  = longint'($signed(data));
			CFG_IMASS:    inv_mass   = longint'(data);
			CFG_DAMP:     damp_gain  = longint'(data);
			CFG_STIFF:    stiff_gain = longint'(data);
			CFG_OLIM:     off_lim    = longint'(data[30:0]);
			CFG_VLIM:     vel_lim    = longint'(data[30:0]);
			CFG_WEIGHT:   smooth_w   = longint'(data[16:0]);
			CFG_FLOOR_EN: floor_en   = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Full register set, only ever from idle.
	task automatic load_gains(logic [31:0] target, logic [31:0] imass, logic [31:0] damp,
			logic [31:0] stiff, logic [31:0] olim, logic [31:0] vlim,
			logic [31:0] weight, logic [31:0] floor_on);
		settle();
		write_register(CFG_TARGET, target);
		write_register(CFG_IMASS, imass);
		write_register(CFG_DAMP, damp);
		write_register(CFG_STIFF, stiff);
		write_register(CFG_OLIM, olim);
		write_register(CFG_VLIM, vlim);
		write_register(CFG_WEIGHT, weight);
		write_register(CFG_FLOOR_EN, floor_on);
	endtask

	// Gains that keep the axis moving inside its limits, or wild ones.
	task automatic random_gains(bit wild);
		if (wild)
			load_gains($urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom(), $urandom(), $urandom());
		else
			load_gains(32'($urandom_range(0, 80 << 16)) - 32'(20 << 16),
				$urandom_range(1 << 13, 1 << 18), $urandom_range(0, 100 << 16),
				$urandom_range(0, 1000 << 16), $urandom_range(0, 1 << 23),
				$urandom_range(0, 1 << 24), $urandom_range(0, 70000),
				$urandom_range(0, 1));
	endtask

	// Mostly forces near the target with sane steps; some full-range noise and resets.
	function automatic req_t random_req();
		logic        kind;
		logic [31:0] f;
		logic [23:0] dt;
		kind = ($urandom_range(0, 15) == 0) ? REQ_RESET : REQ_UPDATE;
		if ($urandom_range(0, 7) == 0)
			f = $urandom();
		else
			f = tgt_force[31:0] + 32'($urandom_range(0, 60 << 16)) - 32'(30 << 16);
		case ($urandom_range(0, 9))
			0:       dt = '0;
			1:       dt = 24'($urandom());
			2:       dt = 24'(DtMax);
			default: dt = 24'($urandom_range(1, DtMax));
		endcase
		return make_req(kind, f, dt);
	endfunction

	// ------------------------------------------------------------------
	// Response side: stall bursts, long hold-off on request, and checking.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_left != 0) begin
			rsp_stall = 1'b1;
			hold_left--;
		end else if (burst_left != 0) begin
			rsp_stall = 1'b1;
			burst_left--;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			rsp_stall  = 1'b1;
			burst_left = $urandom_range(0, 15);
		end else begin
			rsp_stall = 1'b0;
		end
	end

	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_motion.size() == 0) begin
				log_mismatch("result beat with nothing pending", rsp.offset_out, '0);
			end else begin
				want = expected_motion.pop_front();
				if (rsp.offset_out !== want.offset_out)
					log_mismatch("offset_out", rsp.offset_out, want.offset_out);
				if (rsp.velocity_out !== want.velocity_out)
					log_mismatch("velocity_out", rsp.velocity_out, want.velocity_out);
				if (rsp.filtered_out !== want.filtered_out)
					log_mismatch("filtered_out", rsp.filtered_out, want.filtered_out);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				expected_motion.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Default registers: zero limits keep the axis still; first update loads the filter.
	task automatic test_first_update();
		send_beat(make_req(REQ_UPDATE, 32'h7FFF_FFFF, 24'hFF_FFFF));
		send_beat(make_req(REQ_UPDATE, 32'h8000_0000, 24'h00_0000));  // floored to zero
		send_beat(make_req(REQ_RESET, 32'h1234_5678, 24'hAB_CDEF));   // step ignored
		send_beat(make_req(REQ_RESET, 32'hFFF0_0000, 24'h00_0001));   // negative, floored
	endtask

	// Axis driven into its offset limit, zero and long steps, then limits pulled in.
	task automatic test_directed_motion();
		load_gains(32'(1 << 16), 32'd65536, 32'(2 << 16), 32'(10 << 16),
			32'(1 << 22), 32'(1 << 24), 32'h1_FFFF, 32'd1);  // weight above one
		send_beat(make_req(REQ_RESET, -32'sd5 <<< 16, 24'd0));
		repeat (4)
			send_beat(make_req(REQ_UPDATE, 32'(40 << 16), 24'hFF_FFFF));  // long step
		send_beat(make_req(REQ_UPDATE, 32'(40 << 16), 24'd0));             // zero step
		send_beat(make_req(REQ_UPDATE, 32'(40 << 16), 24'(DtMax)));
		send_beat(make_req(REQ_UPDATE, 32'(40 << 16), 24'(DtMax + 1)));
		// stored offset and velocity now beyond the new limits
		load_gains(32'(1 << 16), 32'd65536, 32'(2 << 16), 32'(10 << 16),
			32'(1 << 18), 32'(1 << 20), 32'd0, 32'd0);
		send_beat(make_req(REQ_UPDATE, -32'sd40 <<< 16, 24'd10000));
		send_beat(make_req(REQ_UPDATE, -32'sd40 <<< 16, 24'd0));
	endtask

	// Every register at an extreme; unfloored target at minimum saturates the net force.
	task automatic test_saturation();
		load_gains(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd0);
		send_beat(make_req(REQ_UPDATE, 32'h7FFF_FFFF, 24'(DtMax)));
		send_beat(make_req(REQ_UPDATE, 32'h7FFF_FFFF, 24'(DtMax)));
		send_beat(make_req(REQ_UPDATE, 32'h8000_0000, 24'd1));
		load_gains(32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd65536, 32'd1);
		send_beat(make_req(REQ_UPDATE, 32'h8000_0000, 24'hFF_FFFF));
		send_beat(make_req(REQ_UPDATE, 32'h7FFF_FFFF, 24'(DtMax)));
	endtask

	// Receiver holds off long enough that the block backs up onto the request side.
	task automatic test_backpressure();
		random_gains(1'b0);
		hold_left = 300;
		repeat (40) send_beat(random_req());
	endtask

	// Random phases, one of them with wild registers; the last runs without idling.
	task automatic test_random_phases();
		for (int phase = 0; phase < 5; phase++) begin
			random_gains(phase == 1);
			idle_en = (phase != 4);
			repeat (250) send_beat(random_req());
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		rsp_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_first_update();
		test_directed_motion();
		test_saturation();
		test_backpressure();
		test_random_phases();

		settle();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== admittance_offset_integrator_unit.f =====
rtl/core/aoi_pkg.sv
rtl/core/admittance_offset_integrator_unit.sv
rtl/core/aoi_checker.sv
tb/admittance_offset_integrator_unit_tb.sv
